[src/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the partition fit allocator
// Widths, policy and register codes, and the scan packet that travels
// along the row of partition cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int IDX_W          = 4;   // partition index width
  localparam int SIZE_W         = 16;  // partition / request size width
  localparam int CNT_W          = 5;   // partition count register width
  localparam int POL_W          = 3;   // policy register width
  localparam int CFG_IDX_W      = 2;   // config register index width
  localparam int CFG_DATA_W     = 5;   // config write data width

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTITIONS);

  // allocation policies
  localparam logic [POL_W-1:0] POL_FIRST = 3'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 3'd1;
  localparam logic [POL_W-1:0] POL_WORST = 3'd2;
  localparam logic [POL_W-1:0] POL_NEXT  = 3'd3;
  localparam logic [POL_W-1:0] POL_LAST  = 3'd4;

  // request actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

  // search packet handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] req;        // requested size
    logic [IDX_W-1:0]  start;      // next fit start index
    logic              found;      // main candidate (next fit: at/after start)
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic              alt_found;  // next fit: first fit from partition 0
    logic [IDX_W-1:0]  alt_idx;
    logic [SIZE_W-1:0] alt_size;
  } scan_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic              load_en;    // overwrite a partition size
    logic              sub_en;     // subtract a granted request
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[src/pfa_in_if.sv]
// ----------------------------------------------------------------------------
// pfa_in_if: request channel of the partition fit allocator
// Valid/ready channel carrying a load or an allocate request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_in_if import pfa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  load_index;
  logic [SIZE_W-1:0] size_value;

  modport source (output valid, action, load_index, size_value, input ready);
  modport sink   (input valid, action, load_index, size_value, output ready);

endinterface

`default_nettype wire

[src/pfa_out_if.sv]
// ----------------------------------------------------------------------------
// pfa_out_if: result channel of the partition fit allocator
// Valid/ready channel carrying the outcome of one allocate request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_out_if import pfa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              granted;
  logic [IDX_W-1:0]  chosen_partition;
  logic [SIZE_W-1:0] remaining_after;

  modport source (output valid, granted, chosen_partition, remaining_after, input ready);
  modport sink   (input valid, granted, chosen_partition, remaining_after, output ready);

endinterface

`default_nettype wire

[src/pfa_cfg_if.sv]
// ----------------------------------------------------------------------------
// pfa_cfg_if: configuration write channel of the partition fit allocator
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_cfg_if import pfa_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

`default_nettype wire

[src/pfa_cell.sv]
// ----------------------------------------------------------------------------
// pfa_cell: one partition cell
// Holds one partition's remaining size, folds it into the passing search
// packet and hands the packet to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_cell import pfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [POL_W-1:0] policy_i,
  input  logic [CNT_W-1:0] count_i,
  input  cell_cmd_t        cmd_i,
  input  scan_t            pkt_i,
  output scan_t            pkt_o
);

  logic [SIZE_W-1:0] size_q;
  scan_t             pkt_d;
  scan_t             pkt_q;
  logic              in_use;
  logic              fits;
  logic              sel;

  // stored size: loads overwrite, grants subtract
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && (cmd_i.idx == cell_idx_i)) begin
      size_q <= cmd_i.value;
    end else if (cmd_i.sub_en && (cmd_i.idx == cell_idx_i)) begin
      size_q <= size_q - cmd_i.value;
    end
  end

  assign in_use = ({1'b0, cell_idx_i} < count_i);
  assign fits   = pkt_i.valid && in_use && (size_q >= pkt_i.req);

  // policy decision for this cell
  always_comb begin
    pkt_d = pkt_i;
    sel   = 1'b0;
    unique case (policy_i)
      POL_BEST:  sel = fits && (!pkt_i.found || (size_q <= pkt_i.size));
      POL_WORST: sel = fits && (!pkt_i.found || (size_q >= pkt_i.size));
      POL_LAST:  sel = fits;
      POL_NEXT: begin
        sel = fits && !pkt_i.found && (cell_idx_i >= pkt_i.start);
        if (fits && !pkt_i.alt_found) begin
          pkt_d.alt_found = 1'b1;
          pkt_d.alt_idx   = cell_idx_i;
          pkt_d.alt_size  = size_q;
        end
      end
      default:   sel = fits && !pkt_i.found;
    endcase
    if (sel) begin
      pkt_d.found = 1'b1;
      pkt_d.idx   = cell_idx_i;
      pkt_d.size  = size_q;
    end
  end

  // hand to neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

`default_nettype wire

[src/partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// partition_fit_allocator: fixed partition allocator, first/best/worst/
// next/last fit
//
// Requests come in on in_req. A load request (action 0) writes one
// partition size and is done in the cycle it is accepted; it gives no
// result. An allocate request (action 1) starts a search packet down a row
// of 16 partition cells, one cell per cycle. The last cell's packet names
// the chosen partition, which is then reduced by the request size and one
// result goes out on out_res.
// Path: an allocate passes the launch register, the 16 cells of the row,
// the capture register of the last cell's packet and the output register.
// Requests are taken one at a time, so the next request is accepted the
// cycle after the result is registered; loads are taken back to back.
// The result sits in an output register. If the receiver stalls, the
// finished search waits, the write back is held until the result can be
// registered, and no new request is accepted meanwhile.
// cfg writes policy (index 0) and partition count (index 1); they are
// taken at any time and are meant for idle periods.
// Reset sets policy to first fit, count to 16 and the next fit pointer to
// 0; partition sizes are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator import pfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfa_in_if.sink    in_req,
  pfa_out_if.source out_res,
  pfa_cfg_if.sink   cfg
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [POL_W-1:0]  policy_q;
  logic [CNT_W-1:0]  pcount_q;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  ptr_q;
  scan_t             launch_d;
  scan_t             launch_q;
  scan_t             fin_q;
  scan_t             chain [MAX_PARTITIONS+1];
  cell_cmd_t         cmd;
  logic              in_acc;
  logic              release_res;
  logic              use_alt;
  logic              res_granted;
  logic [IDX_W-1:0]  res_idx;
  logic [SIZE_W-1:0] res_size;
  logic [CNT_W-1:0]  ptr_inc;
  logic              out_valid_q;
  logic              out_granted_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [SIZE_W-1:0] out_rem_q;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      pcount_q <= CNT_MAX;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_POLICY) begin
        policy_q <= cfg.data[POL_W-1:0];
      end else if (cfg.index == CFG_COUNT) begin
        pcount_q <= cfg.data[CNT_W-1:0];
      end
    end
  end

  assign count = (pcount_q > CNT_MAX) ? CNT_MAX : pcount_q;

  // request handshake
  assign in_req.ready = (state_q == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  // finished search: next fit falls back to the wrapped candidate
  assign use_alt     = (policy_q == POL_NEXT) && !fin_q.found;
  assign res_granted = use_alt ? fin_q.alt_found : fin_q.found;
  assign res_idx     = use_alt ? fin_q.alt_idx : fin_q.idx;
  assign res_size    = use_alt ? fin_q.alt_size : fin_q.size;
  assign ptr_inc     = {1'b0, res_idx} + CNT_W'(1);

  assign release_res = (state_q == ST_WAIT) && (!out_valid_q || out_res.ready);

  // write command to the cells
  always_comb begin
    cmd = '0;
    if (in_acc && (in_req.action == ACT_LOAD)) begin
      cmd.load_en = 1'b1;
      cmd.idx     = in_req.load_index;
      cmd.value   = in_req.size_value;
    end else if (release_res && res_granted) begin
      cmd.sub_en = 1'b1;
      cmd.idx    = res_idx;
      cmd.value  = fin_q.req;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && (in_req.action == ACT_ALLOC)) state_d = ST_SCAN;
      ST_SCAN: if (chain[MAX_PARTITIONS].valid) state_d = ST_WAIT;
      ST_WAIT: if (release_res) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // launch packet for the first cell
  always_comb begin
    launch_d       = '0;
    launch_d.valid = in_acc && (in_req.action == ACT_ALLOC);
    launch_d.req   = in_req.size_value;
    launch_d.start = ({1'b0, ptr_q} < count) ? ptr_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // row of partition cells
  assign chain[0] = launch_q;

  for (genvar k = 0; k < MAX_PARTITIONS; k++) begin : g_cell
    pfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(k)),
      .policy_i   (policy_q),
      .count_i    (count),
      .cmd_i      (cmd),
      .pkt_i      (chain[k]),
      .pkt_o      (chain[k+1])
    );
  end

  // capture the packet leaving the last cell
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && chain[MAX_PARTITIONS].valid) begin
      fin_q <= chain[MAX_PARTITIONS];
    end
  end

  // next fit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (release_res && res_granted && (policy_q == POL_NEXT)) begin
      ptr_q <= (ptr_inc >= count) ? '0 : ptr_inc[IDX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (release_res) begin
      out_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (release_res) begin
      out_granted_q <= res_granted;
      out_idx_q     <= res_granted ? res_idx : '0;
      out_rem_q     <= res_granted ? (res_size - fin_q.req) : '0;
    end
  end

  assign out_res.valid            = out_valid_q;
  assign out_res.granted          = out_granted_q;
  assign out_res.chosen_partition = out_idx_q;
  assign out_res.remaining_after  = out_rem_q;

  // checks
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_req.ready)
    else $error("request accepted during a search");

  a_launch_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q.valid |=> !launch_q.valid)
    else $error("search launched twice");

  a_last_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_PARTITIONS].valid |-> (state_q == ST_SCAN))
    else $error("search packet left the row outside a scan");

  a_grant_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (release_res && res_granted) |-> ({1'b0, res_idx} < count))
    else $error("granted a partition that is not in use");

endmodule

`default_nettype wire

[tb/sv/tb_partition_fit_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_partition_fit_allocator: self-checking bench for the partition allocator
// Walks a short directed table (count zero, extreme sizes, refusals, ties,
// next fit with a stale pointer, a reserved policy code), then runs random
// phases that cycle through every policy and several partition counts under
// changing idle and stall patterns. Every result is compared field by field
// with a scoreboard fed by a cycle-free model of the partition table.
// ----------------------------------------------------------------------------

module tb_partition_fit_allocator;
  import pfa_pkg::*;

  localparam logic [POL_W-1:0] POL_RSVD = 3'd7;  // unused code, decodes as first fit

  localparam int PHASES        = 24;
  localparam int PHASE_ITEMS   = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int N_DIR         = 28;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  part;
    logic [SIZE_W-1:0] left;
  } alloc_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  act;
    logic [IDX_W-1:0]      idx;
    logic [SIZE_W-1:0]     size;
    logic                  typed;   // res holds a hand-written expectation
    alloc_res_t            res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  pfa_in_if  in_bus ();
  pfa_out_if res_bus ();
  pfa_cfg_if cfg_bus ();

  partition_fit_allocator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_bus),
    .out_res (res_bus),
    .cfg     (cfg_bus)
  );

  // Shadow of the partition table and registers
  logic [SIZE_W-1:0] part_size [MAX_PARTITIONS] = '{default: '0};
  logic [IDX_W-1:0]  nf_ptr      = '0;
  logic [POL_W-1:0]  cfg_policy  = POL_FIRST;
  logic [CNT_W-1:0]  cfg_count   = CNT_MAX;
  bit                loaded [MAX_PARTITIONS] = '{default: 1'b0};

  alloc_res_t grant_q [$];
  int         fail_count = 0;

  // Hand-written expectation for the request being offered
  logic       pend_typed = 1'b0;
  alloc_res_t pend_res   = '0;

  // Flow control knobs
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  logic        hold_arm  = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  // Clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run time guard
  initial begin
    #4_000_000;
    $display("partition_fit_allocator regression: fail");
    $finish;
  end

  // Table row builders
  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row          = '0;
    row.kind     = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic dir_row_t load_row(input logic [IDX_W-1:0] idx,
                                        input logic [SIZE_W-1:0] size);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.act  = ACT_LOAD;
    row.idx  = idx;
    row.size = size;
    return row;
  endfunction

  function automatic dir_row_t alloc_row(input logic [SIZE_W-1:0] size);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.act  = ACT_ALLOC;
    row.size = size;
    return row;
  endfunction

  function automatic dir_row_t alloc_chk(input logic [SIZE_W-1:0] size,
                                         input logic [IDX_W-1:0] part,
                                         input logic [SIZE_W-1:0] left);
    dir_row_t row;
    row       = alloc_row(size);
    row.typed = 1'b1;
    row.res   = '{granted: 1'b1, part: part, left: left};
    return row;
  endfunction

  // Refused request: all result fields zero
  function automatic dir_row_t alloc_none(input logic [SIZE_W-1:0] size);
    dir_row_t row;
    row       = alloc_row(size);
    row.typed = 1'b1;
    return row;
  endfunction

  // Directed table; rows after a policy or count change run once all is idle
  dir_row_t dir_tbl [N_DIR] = '{
    cfg_row(CFG_COUNT, 5'd0),
    alloc_none(16'd0),                      // no partition in use
    cfg_row(CFG_COUNT, 5'd3),
    load_row(4'd0, 16'd100),
    load_row(4'd1, 16'hFFFF),
    load_row(4'd2, 16'd100),
    alloc_chk(16'd0, 4'd0, 16'd100),        // zero request, first fit
    alloc_chk(16'hFFFF, 4'd1, 16'd0),       // largest request, exact fit
    alloc_none(16'd101),
    cfg_row(CFG_POLICY, POL_BEST),
    load_row(4'd1, 16'd50),
    alloc_row(16'd40),
    alloc_row(16'd60),                      // tie between 0 and 2
    cfg_row(CFG_POLICY, POL_WORST),
    alloc_row(16'd5),
    cfg_row(CFG_POLICY, POL_NEXT),
    alloc_row(16'd1),
    alloc_row(16'd1),
    alloc_none(16'hFFFF),                   // pointer must stay put
    cfg_row(CFG_COUNT, 5'd2),               // pointer now past the count
    alloc_row(16'd1),
    load_row(4'd3, 16'h8000),               // above the count, still written
    cfg_row(CFG_COUNT, 5'd4),
    cfg_row(CFG_POLICY, POL_LAST),
    alloc_chk(16'h8000, 4'd3, 16'd0),
    alloc_row(16'd1),
    cfg_row(CFG_POLICY, {2'b11, POL_RSVD}),
    alloc_row(16'd2)
  };

  // Picks a partition for one request and applies it to the shadow table
  function automatic alloc_res_t predict_alloc(input logic [SIZE_W-1:0] req);
    alloc_res_t        res;
    int                active;
    int                pick;
    int                slot;
    logic [SIZE_W-1:0] best_sz;
    active  = (cfg_count > CNT_MAX) ? MAX_PARTITIONS : int'(cfg_count);
    pick    = -1;
    best_sz = '0;
    res     = '0;
    case (cfg_policy)
      POL_BEST: begin
        for (int i = 0; i < active; i++)
          if (part_size[i] >= req && (pick < 0 || part_size[i] <= best_sz)) begin
            pick    = i;
            best_sz = part_size[i];
          end
      end
      POL_WORST: begin
        for (int i = 0; i < active; i++)
          if (part_size[i] >= req && (pick < 0 || part_size[i] >= best_sz)) begin
            pick    = i;
            best_sz = part_size[i];
          end
      end
      POL_NEXT: begin
        // stale pointer restarts the scan at partition 0
        slot = (int'(nf_ptr) < active) ? int'(nf_ptr) : 0;
        for (int i = 0; i < active; i++) begin
          if (part_size[slot] >= req) begin
            pick = slot;
            break;
          end
          slot = (slot + 1 >= active) ? 0 : slot + 1;
        end
      end
      POL_LAST: begin
        for (int i = 0; i < active; i++)
          if (part_size[i] >= req) pick = i;
      end
      default: begin
        for (int i = 0; i < active; i++)
          if (part_size[i] >= req) begin
            pick = i;
            break;
          end
      end
    endcase
    if (pick >= 0) begin
      part_size[pick] = part_size[pick] - req;
      if (cfg_policy == POL_NEXT) nf_ptr = IDX_W'((pick + 1 >= active) ? 0 : pick + 1);
      res.granted = 1'b1;
      res.part    = IDX_W'(pick);
      res.left    = part_size[pick];
    end
    return res;
  endfunction

  // Random request, weighted toward exact fits, ties and small sizes
  function automatic dir_row_t rand_item();
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.idx  = IDX_W'($urandom_range(MAX_PARTITIONS - 1));
    if ($urandom_range(99) < 30) begin
      row.act = ACT_LOAD;
      case ($urandom_range(5))
        0:       row.size = '0;
        1:       row.size = '1;
        2:       row.size = part_size[$urandom_range(MAX_PARTITIONS - 1)];
        3:       row.size = SIZE_W'($urandom_range(255));
        default: row.size = SIZE_W'($urandom());
      endcase
    end else begin
      row.act = ACT_ALLOC;
      case ($urandom_range(9))
        0:       row.size = '0;
        1:       row.size = '1;
        2, 3:    row.size = part_size[$urandom_range(MAX_PARTITIONS - 1)];
        4, 5, 6: row.size = SIZE_W'($urandom_range(2047));
        default: row.size = SIZE_W'($urandom());
      endcase
    end
    return row;
  endfunction

  // Offer one request, idling first at random; returns at the falling edge
  // after it was taken, with valid left high
  task automatic send_item(input dir_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= row.act;
    in_bus.load_index <= row.idx;
    in_bus.size_value <= row.size;
    pend_typed = row.typed;
    pend_res   = row.res;
    do @(posedge clk_i); while (!in_bus.ready);
    if (row.act == ACT_LOAD) loaded[row.idx] = 1'b1;
    @(negedge clk_i);
  endtask

  // Drain all outstanding results, then let the search row empty
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write; returns after valid has dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == CFG_POLICY) cfg_policy = data[POL_W-1:0];
    else if (idx == CFG_COUNT) cfg_count = data;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Accepted requests update the shadow table and queue the expected grant
  always @(posedge clk_i) begin : req_monitor
    alloc_res_t want;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      if (in_bus.action == ACT_LOAD) begin
        part_size[in_bus.load_index] = in_bus.size_value;
      end else begin
        want    = predict_alloc(in_bus.size_value);
        want    = pend_typed ? pend_res : want;
        grant_q = {grant_q, want};
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : grant_check
    alloc_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (grant_q.size() == 0) begin
        $error("result with no request pending: granted %0d partition %0d left %0d",
               res_bus.granted, res_bus.chosen_partition, res_bus.remaining_after);
        fail_count++;
      end else begin
        want = grant_q.pop_front();
        if (res_bus.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, res_bus.granted);
          fail_count++;
        end
        if (res_bus.chosen_partition !== want.part) begin
          $error("chosen_partition: expected %0d, got %0d", want.part,
                 res_bus.chosen_partition);
          fail_count++;
        end
        if (res_bus.remaining_after !== want.left) begin
          $error("remaining_after: expected %0d, got %0d", want.left,
                 res_bus.remaining_after);
          fail_count++;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when armed
  always @(negedge clk_i) begin : res_sink
    if (hold_arm != hold_seen) begin
      hold_seen = hold_arm;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [CNT_W-1:0] cnt;
    logic [POL_W-1:0] pol;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_LOAD;
    in_bus.load_index  = '0;
    in_bus.size_value  = '0;
    res_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_POLICY;
    cfg_bus.data       = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows
    for (int k = 0; k < N_DIR; k++) begin
      if (dir_tbl[k].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tbl[k].reg_idx, dir_tbl[k].reg_data);
      end else begin
        send_item(dir_tbl[k]);
      end
    end

    // random phases: policy walks all eight codes, count hits its extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       cnt = CNT_MAX;
        1:       cnt = '1;
        2:       cnt = '0;
        3:       cnt = CNT_W'(1);
        default: begin
          case ($urandom_range(4))
            0:       cnt = CNT_W'($urandom_range(31, 17));
            1:       cnt = CNT_MAX;
            default: cnt = CNT_W'($urandom_range(15, 1));
          endcase
        end
      endcase
      pol = POL_W'(ph % 8);
      write_reg(CFG_POLICY, {2'($urandom_range(3)), pol});
      write_reg(CFG_COUNT, cnt);

      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 46;
          sink_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct <= 46;
        end
        default: begin
          sender_idle_pct = 14;
          sink_stall_pct <= 14;
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 5) hold_arm <= ~hold_arm;

      // every partition gets a size before anything can read it
      if (ph == 0) begin
        for (int i = 0; i < MAX_PARTITIONS; i++)
          if (!loaded[i]) send_item(load_row(IDX_W'(i), SIZE_W'($urandom())));
      end
      repeat (PHASE_ITEMS) send_item(rand_item());
    end

    wait_idle();
    if (fail_count == 0 && grant_q.size() == 0) begin
      $display("partition_fit_allocator regression: pass");
    end else begin
      $display("partition_fit_allocator regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pfa_pkg.sv
src/pfa_in_if.sv
src/pfa_out_if.sv
src/pfa_cfg_if.sv
src/pfa_cell.sv
src/partition_fit_allocator.sv
tb/sv/tb_partition_fit_allocator.sv
